>>> design/chroma_key_range_blend_macros.svh
// Assertion macros shared by the chroma keyer modules.
`ifndef CHROMA_KEY_RANGE_BLEND_MACROS_SVH
`define CHROMA_KEY_RANGE_BLEND_MACROS_SVH
`ifndef SYNTHESIS
`define CKRB_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("ckrb assertion failed");
`define CKRB_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("ckrb assertion failed");
`else
`define CKRB_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define CKRB_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

>>> design/ckrb_pkg.sv
// Shared types and constants for the chroma keyer.
package ckrb_pkg;

	localparam int PIX_W = 24;
	localparam int CH_W = 8;
	localparam int TOL_W = 7;
	localparam int CKRB_QUEUE_DEPTH = 2;
	localparam logic [TOL_W-1:0] CKRB_TOL_RESET = 7'd30;

	// Decision taken by the front end for one pixel
	localparam logic [1:0] KIND_CAMERA = 2'd0;
	localparam logic [1:0] KIND_BACKDROP = 2'd1;
	localparam logic [1:0] KIND_BLEND = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [PIX_W-1:0] raw;
		logic [PIX_W-1:0] bg;
		logic [CH_W-1:0] m1;
		logic [CH_W-1:0] t2;
	} ckrb_item_t;

endpackage

>>> design/ckrb_front.sv
// Front end: accept pixels, blur, measure key distance and classify.
`include "chroma_key_range_blend_macros.svh"
module ckrb_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [ckrb_pkg::PIX_W-1:0] camera_pixel,
	input  logic [ckrb_pkg::PIX_W-1:0] backdrop_pixel,
	input  logic [ckrb_pkg::PIX_W-1:0] key_low_pixel,
	input  logic [ckrb_pkg::PIX_W-1:0] key_high_pixel,
	input  logic frame_start,
	input  logic [ckrb_pkg::TOL_W-1:0] key_tolerance,
	input  logic q_full,
	output logic push,
	output ckrb_pkg::ckrb_item_t item
);
	import ckrb_pkg::*;

	logic [PIX_W-1:0] prev_q;
	logic [CH_W-1:0] dist_ch [3];
	logic [CH_W-1:0] d01;
	logic [CH_W-1:0] d_max;
	logic [TOL_W-1:0] tol;
	logic [8:0] two_d;
	logic [8:0] one_t;
	logic [8:0] three_t;
	logic [8:0] m1_wide;

	assign in_ready = !q_full;
	assign push = in_valid && in_ready;

	// A tolerance of zero behaves as one
	assign tol = (key_tolerance == '0) ? TOL_W'(1) : key_tolerance;

	always_comb begin
		logic [CH_W-1:0] prev_c;
		logic [CH_W-1:0] blur_c;
		logic [CH_W-1:0] lo_c;
		logic [CH_W-1:0] hi_c;
		for (int c = 0; c < 3; c++) begin
			prev_c = frame_start ? '0 : prev_q[c*CH_W +: CH_W];
			blur_c = {1'b0, prev_c[CH_W-1:1]} + {1'b0, camera_pixel[c*CH_W+1 +: CH_W-1]};
			lo_c = key_low_pixel[c*CH_W +: CH_W];
			hi_c = key_high_pixel[c*CH_W +: CH_W];
			if (blur_c < lo_c) begin
				dist_ch[c] = lo_c - blur_c;
			end else if (blur_c > hi_c) begin
				dist_ch[c] = blur_c - hi_c;
			end else begin
				dist_ch[c] = '0;
			end
		end
	end

	assign d01 = (dist_ch[1] > dist_ch[0]) ? dist_ch[1] : dist_ch[0];
	assign d_max = (dist_ch[2] > d01) ? dist_ch[2] : d01;

	assign two_d = {d_max, 1'b0};
	assign one_t = {2'b00, tol};
	assign three_t = {2'b00, tol} + {1'b0, tol, 1'b0};
	assign m1_wide = two_d - one_t;

	always_comb begin
		item.raw = camera_pixel;
		item.bg = backdrop_pixel;
		item.t2 = {tol, 1'b0};
		item.m1 = '0;
		if (two_d > three_t) begin
			item.kind = KIND_CAMERA;
		end else if (two_d < one_t) begin
			item.kind = KIND_BACKDROP;
		end else begin
			item.kind = KIND_BLEND;
			item.m1 = m1_wide[CH_W-1:0];
		end
	end

	// Blur history: last accepted raw pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (push) begin
			prev_q <= camera_pixel;
		end
	end

	`CKRB_ASSERT_IMPLY(a_blend_weight, clk, arst_n, item.kind == KIND_BLEND, item.m1 <= item.t2)

endmodule

>>> design/ckrb_queue.sv
// Short transaction queue between the front and back ends.
`include "chroma_key_range_blend_macros.svh"
module ckrb_queue #(
	parameter int DEPTH = ckrb_pkg::CKRB_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ckrb_pkg::ckrb_item_t wr_item,
	output logic full,
	input  logic pop,
	output ckrb_pkg::ckrb_item_t rd_item,
	output logic empty
);
	import ckrb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ckrb_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`CKRB_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule

>>> design/ckrb_back.sv
// Back end: pass or blend pixels, exact divide by 2t, output register.
`include "chroma_key_range_blend_macros.svh"
module ckrb_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	output logic pop,
	input  ckrb_pkg::ckrb_item_t item,
	output logic out_valid,
	input  logic out_ready,
	output logic [ckrb_pkg::PIX_W-1:0] composited_pixel
);
	import ckrb_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MUL = 3'd1;
	localparam logic [2:0] B_ADD = 3'd2;
	localparam logic [2:0] B_DIV = 3'd3;
	localparam logic [2:0] B_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] cnt_q;
	ckrb_item_t work_q;
	logic [2*CH_W-1:0] pa_q [3];
	logic [2*CH_W-1:0] pb_q [3];
	logic [CH_W-1:0] rem_q [3];
	logic [CH_W-1:0] low_q [3];
	logic out_valid_q;
	logic [PIX_W-1:0] pix_q;
	logic slot_free;
	logic direct_load;
	logic done_load;
	logic [CH_W-1:0] w_bg;
	logic [2*CH_W-1:0] num [3];
	logic [CH_W:0] trial [3];
	logic take [3];

	assign slot_free = !out_valid_q || out_ready;
	assign pop = (state_q == B_IDLE) && !q_empty && ((item.kind == KIND_BLEND) || slot_free);
	assign direct_load = pop && (item.kind != KIND_BLEND);
	assign done_load = (state_q == B_DONE) && slot_free;
	assign w_bg = work_q.t2 - work_q.m1;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num[c] = pa_q[c] + pb_q[c];
			trial[c] = {rem_q[c], low_q[c][CH_W-1]};
			take[c] = (trial[c] >= {1'b0, work_q.t2});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (pop && (item.kind == KIND_BLEND)) begin
						state_q <= B_MUL;
					end
				end
				B_MUL: state_q <= B_ADD;
				B_ADD: begin
					state_q <= B_DIV;
					cnt_q <= '0;
				end
				B_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd7) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (slot_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (direct_load || done_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= item;
		end
		if (direct_load) begin
			case (item.kind)
				KIND_CAMERA: pix_q <= item.raw;
				KIND_BACKDROP: pix_q <= item.bg;
				default: pix_q <= item.bg;
			endcase
		end else if (done_load) begin
			pix_q <= {low_q[2], low_q[1], low_q[0]};
		end
		for (int c = 0; c < 3; c++) begin
			if (state_q == B_MUL) begin
				pa_q[c] <= {{CH_W{1'b0}}, work_q.raw[c*CH_W +: CH_W]} *
					{{CH_W{1'b0}}, work_q.m1};
				pb_q[c] <= {{CH_W{1'b0}}, work_q.bg[c*CH_W +: CH_W]} *
					{{CH_W{1'b0}}, w_bg};
			end
			if (state_q == B_ADD) begin
				// Numerator stays below 256*2t, so the top byte is a valid start remainder
				rem_q[c] <= num[c][2*CH_W-1:CH_W];
				low_q[c] <= num[c][CH_W-1:0];
			end
			if (state_q == B_DIV) begin
				rem_q[c] <= take[c] ? CH_W'(trial[c] - {1'b0, work_q.t2}) : trial[c][CH_W-1:0];
				low_q[c] <= {low_q[c][CH_W-2:0], take[c]};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign composited_pixel = pix_q;

	`CKRB_ASSERT_IMPLY(a_rem_below_divisor, clk, arst_n, state_q == B_DIV, (rem_q[0] < work_q.t2) && (rem_q[1] < work_q.t2) && (rem_q[2] < work_q.t2))
	`CKRB_ASSERT_NEXT(a_blend_starts, clk, arst_n, pop && (item.kind == KIND_BLEND), state_q == B_MUL)

endmodule

>>> design/chroma_key_range_blend.sv
// Top level of the chroma keyer with soft edge.
//
//   port group     dir   width   handshake
//   cfg_*          in    7       cfg_we, no wait  (key tolerance)
//   in_* pixels    in    97      in_valid / in_ready
//   out pixel      out   24      out_valid / out_ready
//
// Pixels that resolve to camera or backdrop pass at one per cycle when the output and back end are free.
// A blended pixel holds the back end through pop, multiply, add and
// eight steps of the three-lane restoring divider, then the output load.
// The queue lets the front end keep accepting while a blend is in progress.
// Reset clears the tolerance to 30, the blur history to zero and the queue.
// A stalled output holds its pixel; the front stalls only when the queue is full.
`include "chroma_key_range_blend_macros.svh"
module chroma_key_range_blend #(
	parameter int QUEUE_DEPTH = ckrb_pkg::CKRB_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ckrb_pkg::TOL_W-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic [ckrb_pkg::PIX_W-1:0] camera_pixel,
	input  logic [ckrb_pkg::PIX_W-1:0] backdrop_pixel,
	input  logic [ckrb_pkg::PIX_W-1:0] key_low_pixel,
	input  logic [ckrb_pkg::PIX_W-1:0] key_high_pixel,
	input  logic frame_start,
	output logic out_valid,
	input  logic out_ready,
	output logic [ckrb_pkg::PIX_W-1:0] composited_pixel
);
	import ckrb_pkg::*;

	// Key tolerance register; the user must write it only while the block is idle, which the block does not enforce
	logic [TOL_W-1:0] tol_q;

	// Front to queue
	logic push;
	logic q_full;
	ckrb_item_t wr_item;

	// Queue to back
	logic pop;
	logic q_empty;
	ckrb_item_t rd_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= CKRB_TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// Classify each accepted transaction and advance the blur history
	ckrb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.camera_pixel   (camera_pixel),
		.backdrop_pixel (backdrop_pixel),
		.key_low_pixel  (key_low_pixel),
		.key_high_pixel (key_high_pixel),
		.frame_start    (frame_start),
		.key_tolerance  (tol_q),
		.q_full         (q_full),
		.push           (push),
		.item           (wr_item)
	);

	// Decouple classification from the multi-cycle blend
	ckrb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.full    (q_full),
		.pop     (pop),
		.rd_item (rd_item),
		.empty   (q_empty)
	);

	// Select or blend, then hold the result until taken
	ckrb_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.pop              (pop),
		.item             (rd_item),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.composited_pixel (composited_pixel)
	);

endmodule

>>> dv/chroma_key_range_blend_tb.sv
// Self-checking testbench for the chroma keyer with soft edge.

// Predicts each composited pixel and holds those still awaited from the block.
class keyed_pixel_board;
	logic [ckrb_pkg::TOL_W-1:0] tolerance;
	logic [ckrb_pkg::PIX_W-1:0] history;
	logic [ckrb_pkg::PIX_W-1:0] awaited_pixels[$];
	int errors;
	int checked;
	int camera_count;
	int backdrop_count;
	int blend_count;

	function new();
		tolerance = ckrb_pkg::CKRB_TOL_RESET;
		history = '0;
		errors = 0;
		checked = 0;
		camera_count = 0;
		backdrop_count = 0;
		blend_count = 0;
	endfunction

	function int blur_ch(logic [ckrb_pkg::PIX_W-1:0] prev, logic [ckrb_pkg::PIX_W-1:0] raw,
			int sh);
		return int'(prev[sh +: 8] >> 1) + int'(raw[sh +: 8] >> 1);
	endfunction

	function logic [ckrb_pkg::PIX_W-1:0] key_pixel(logic [ckrb_pkg::PIX_W-1:0] raw,
			logic [ckrb_pkg::PIX_W-1:0] bg, logic [ckrb_pkg::PIX_W-1:0] klo,
			logic [ckrb_pkg::PIX_W-1:0] khi, logic fs, output logic [1:0] kind);
		logic [ckrb_pkg::PIX_W-1:0] prev;
		logic [ckrb_pkg::PIX_W-1:0] res;
		int t, d, b, lo, hi, cd, t2, m1, v;
		prev = fs ? '0 : history;
		t = (tolerance == 0) ? 1 : int'(tolerance);
		d = 0;
		res = '0;
		for (int sh = 0; sh <= 16; sh += 8) begin
			b = blur_ch(prev, raw, sh);
			lo = int'(klo[sh +: 8]);
			hi = int'(khi[sh +: 8]);
			// below the minimum wins over above the maximum, so inverted ranges fall out too
			cd = (b < lo) ? lo - b : (b > hi) ? b - hi : 0;
			if (cd > d)
				d = cd;
		end
		if (2 * d > 3 * t) begin
			res = raw;
			kind = ckrb_pkg::KIND_CAMERA;
		end else if (2 * d < t) begin
			res = bg;
			kind = ckrb_pkg::KIND_BACKDROP;
		end else begin
			t2 = 2 * t;
			m1 = 2 * d - t;
			for (int sh = 0; sh <= 16; sh += 8) begin
				v = (int'(raw[sh +: 8]) * m1 + int'(bg[sh +: 8]) * (t2 - m1)) / t2;
				res[sh +: 8] = v[7:0];
			end
			kind = ckrb_pkg::KIND_BLEND;
		end
		history = raw;
		return res;
	endfunction

	function void note_pixel(logic [ckrb_pkg::PIX_W-1:0] raw, logic [ckrb_pkg::PIX_W-1:0] bg,
			logic [ckrb_pkg::PIX_W-1:0] klo, logic [ckrb_pkg::PIX_W-1:0] khi, logic fs);
		logic [1:0] kind;
		awaited_pixels.push_back(key_pixel(raw, bg, klo, khi, fs, kind));
		case (kind)
			ckrb_pkg::KIND_CAMERA: camera_count++;
			ckrb_pkg::KIND_BACKDROP: backdrop_count++;
			default: blend_count++;
		endcase
	endfunction

	function void check_pixel(logic [ckrb_pkg::PIX_W-1:0] got);
		logic [ckrb_pkg::PIX_W-1:0] want;
		if (awaited_pixels.size() == 0) begin
			errors++;
			$display("%0t: composited_pixel with none awaited, expected nothing, got %06h",
				$time, got);
			return;
		end
		want = awaited_pixels.pop_front();
		checked++;
		if (got !== want) begin
			errors++;
			$display("%0t: composited_pixel mismatch, expected %06h, got %06h",
				$time, want, got);
		end
	endfunction

	function int pending();
		return awaited_pixels.size();
	endfunction
endclass

module chroma_key_range_blend_tb;
	localparam int CYCLE_LIMIT = 200000;
	// margin for a blend that may still hold the back end
	localparam int TAIL_CYCLES = 20;
	localparam int PHASE_ITEMS = 80;
	localparam int PHASES = 7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ckrb_pkg::TOL_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ckrb_pkg::PIX_W-1:0] camera_pixel = '0;
	logic [ckrb_pkg::PIX_W-1:0] backdrop_pixel = '0;
	logic [ckrb_pkg::PIX_W-1:0] key_low_pixel = '0;
	logic [ckrb_pkg::PIX_W-1:0] key_high_pixel = '0;
	logic frame_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ckrb_pkg::PIX_W-1:0] composited_pixel;

	keyed_pixel_board board = new();

	// last raw pixel offered, so the stimulus can aim the key distance at the soft band
	logic [ckrb_pkg::PIX_W-1:0] last_raw = '0;
	// suppress idling on both sides while set
	bit steady = 1'b0;
	// long holds asked of the receiver, and those it has started
	int stall_requests = 0;
	int stalls_served = 0;
	int hold_left = 0;
	int cycles = 0;
	int settings_written = 0;
	int tol_plan[PHASES] = '{1, 127, 0, 0, 30, 0, 64};

	chroma_key_range_blend dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.camera_pixel(camera_pixel),
		.backdrop_pixel(backdrop_pixel),
		.key_low_pixel(key_low_pixel),
		.key_high_pixel(key_high_pixel),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.composited_pixel(composited_pixel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sample both channels at the rising edge. Note the input transaction first so that
	// a result leaving in the same cycle still finds its expectation queued.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_pixel(camera_pixel, backdrop_pixel, key_low_pixel,
					key_high_pixel, frame_start);
			if (out_valid && out_ready)
				board.check_pixel(composited_pixel);
		end
	end

	// Receiver: drop ready with a one-in-ten chance, or hold it low for a long stretch
	// on request so the queue fills and the block stalls its input.
	always @(negedge clk) begin
		if (stall_requests != stalls_served) begin
			hold_left = 90;
			stalls_served++;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= steady || ($urandom_range(0, 99) >= 10);
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Watchdog expired after %0d cycles, %0d pixels still awaited",
				cycles, board.pending());
			$display("Verification failed");
			$finish;
		end
	end

	// Offer one pixel and hold it until the transaction completes. Idle cycles go in
	// front of the pixel, so valid is only ever raised at a falling edge.
	task automatic send_pixel(logic [ckrb_pkg::PIX_W-1:0] raw, logic [ckrb_pkg::PIX_W-1:0] bg,
			logic [ckrb_pkg::PIX_W-1:0] klo, logic [ckrb_pkg::PIX_W-1:0] khi, logic fs);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		camera_pixel <= raw;
		backdrop_pixel <= bg;
		key_low_pixel <= klo;
		key_high_pixel <= khi;
		frame_start <= fs;
		do
			@(posedge clk);
		while (!in_ready);
		last_raw = raw;
	endtask

	// Random pixel. Most pick a key range that puts the distance near the soft band of
	// the current tolerance; the rest are fully random or spread over all distances.
	task automatic send_random_pixel();
		logic [ckrb_pkg::PIX_W-1:0] raw, bg, klo, khi;
		logic fs;
		int t, dt, lo_d, hi_d, sel, dc, b, mode;
		raw = 24'($urandom);
		bg = 24'($urandom);
		fs = ($urandom_range(0, 99) < 8);
		mode = $urandom_range(0, 99);
		klo = 24'($urandom);
		khi = 24'($urandom);
		if (mode >= 25) begin
			t = (board.tolerance == 0) ? 1 : int'(board.tolerance);
			lo_d = (t > 3) ? t / 2 - 1 : 0;
			hi_d = (3 * t) / 2 + 2;
			if (hi_d > 255)
				hi_d = 255;
			dt = (mode < 85) ? $urandom_range(lo_d, hi_d) : $urandom_range(0, 255);
			sel = $urandom_range(0, 2);
			for (int ch = 0; ch < 3; ch++) begin
				b = board.blur_ch(fs ? '0 : last_raw, raw, ch * 8);
				dc = (ch == sel) ? dt : $urandom_range(0, dt);
				// clamp a distance that cannot be reached from this blurred value
				if (dc > b && b + dc > 255)
					dc = (b > 255 - b) ? b : 255 - b;
				if (dc == 0) begin
					klo[ch * 8 +: 8] = 8'($urandom_range(0, b));
					khi[ch * 8 +: 8] = 8'($urandom_range(b, 255));
				end else if (dc <= b && (b + dc > 255 || $urandom_range(0, 1) == 1)) begin
					// above the maximum; the minimum may sit above it (inverted range)
					khi[ch * 8 +: 8] = 8'(b - dc);
					klo[ch * 8 +: 8] = 8'($urandom_range(0, b));
				end else begin
					// below the minimum; any maximum will do
					klo[ch * 8 +: 8] = 8'(b + dc);
				end
			end
		end
		send_pixel(raw, bg, klo, khi, fs);
	endtask

	// Drop valid and hold off until every awaited pixel has come back.
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic set_tolerance(logic [ckrb_pkg::TOL_W-1:0] value);
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.tolerance = value;
		settings_written++;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset tolerance of 30.
		// key inside range everywhere: backdrop
		send_pixel(24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b1);
		// far outside range: camera, then again with blur history in play
		send_pixel(24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 1'b0);
		send_pixel(24'hFFFFFF, 24'h123456, 24'h000000, 24'h000000, 1'b0);
		// lower edge of the soft band (2d = t): blend weights pick the backdrop
		send_pixel(24'h000000, 24'hA5A5A5, 24'h0F0F0F, 24'hFFFFFF, 1'b1);
		// upper edge of the soft band (2d = 3t): blend weights pick the camera
		send_pixel(24'h000000, 24'hA5A5A5, 24'h2D0000, 24'hFFFFFF, 1'b1);
		// middle of the band
		send_pixel(24'h00FF80, 24'h8040FF, 24'h1E0000, 24'hFFFFFF, 1'b1);
		// inverted key ranges, value below the minimum and above the maximum
		send_pixel(24'hA04020, 24'h55AA55, 24'h801040, 24'h200830, 1'b1);
		send_pixel(24'h808080, 24'h0F0F0F, 24'hC0C0C0, 24'h404040, 1'b1);
		// blur mixes the previous raw pixel
		send_pixel(24'h102030, 24'hFEDCBA, 24'h101010, 24'h181818, 1'b0);
		// widest distance
		send_pixel(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);

		// zero tolerance acts as one
		set_tolerance(7'd0);
		send_pixel(24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b1);
		send_pixel(24'h000000, 24'hFFFFFF, 24'h010101, 24'hFFFFFF, 1'b1);
		send_pixel(24'h000000, 24'hFFFFFF, 24'h020202, 24'hFFFFFF, 1'b1);

		// largest tolerance, straddle both band edges
		set_tolerance(7'd127);
		send_pixel(24'h000000, 24'hFFFFFF, 24'h3F0000, 24'hFFFFFF, 1'b1);
		send_pixel(24'h000000, 24'hFFFFFF, 24'h400000, 24'hFFFFFF, 1'b1);
		send_pixel(24'h0000FF, 24'hFF00FF, 24'hBE0000, 24'hFFFFFF, 1'b1);
		send_pixel(24'h0000FF, 24'hFF00FF, 24'hBF0000, 24'hFFFFFF, 1'b1);

		// Random part, one tolerance per phase.
		tol_plan[3] = $urandom_range(2, 126);
		tol_plan[5] = $urandom_range(0, 127);
		for (int p = 0; p < PHASES; p++) begin
			set_tolerance(7'(tol_plan[p]));
			// phase 3 runs with no idling on either side
			steady = (p == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 1 && i == 20)
					stall_requests++;
				if (p == 4 && i == 40)
					wait_for_drain();
				send_random_pixel();
			end
		end
		steady = 1'b0;

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d composited pixels: %0d camera, %0d backdrop, %0d blended,",
			board.checked, board.camera_count, board.backdrop_count, board.blend_count);
		$display("over %0d tolerance writes including 0, 1 and 127, with back-pressure stalls.",
			settings_written);
		if (board.errors == 0 && board.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
